>>> hw/rtl/ccgr_pkg.sv
// Shared types, constants and the 5x7 font table of the character cell rasterizer.
package ccgr_pkg;

  // Widths of the configuration registers and of the result fields
  localparam int CFG_W      = 7;
  localparam int CODE_W     = 8;
  localparam int ROW_IDX_W  = 6;
  localparam int PIX_W      = 64;

  // Glyph geometry and the code range that carries a glyph
  localparam int GLYPH_W      = 5;
  localparam int GLYPH_H      = 7;
  localparam int GLYPH_COUNT  = 94;
  localparam int GLYPH_IDX_W  = 7;
  localparam logic [CODE_W-1:0] GLYPH_FIRST = 8'd33;
  localparam logic [CODE_W-1:0] GLYPH_LAST  = 8'd126;

  // Default cell size limits and register reset values
  localparam int MAX_CELL_WIDTH_DEF  = 64;
  localparam int MAX_CELL_HEIGHT_DEF = 64;
  localparam logic [CFG_W-1:0] CELL_WIDTH_RST  = 7'd8;
  localparam logic [CFG_W-1:0] CELL_HEIGHT_RST = 7'd16;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Register index, decoded from paddr[2]
  typedef enum logic {
    REG_CELL_WIDTH  = 1'b0,
    REG_CELL_HEIGHT = 1'b1
  } reg_idx_t;

  // One glyph: seven rows of five bits, bit 4 is the leftmost column
  typedef logic [0:GLYPH_H-1][GLYPH_W-1:0] glyph_t;

  // Queue status seen by the producer and consumer
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Font table for codes 33..126
  localparam glyph_t GLYPH_ROM [GLYPH_COUNT] = '{
    '{5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04}, '{5'h0A,5'h0A,5'h00,5'h00,5'h00,5'h00,5'h00},
    '{5'h0A,5'h1F,5'h0A,5'h0A,5'h1F,5'h0A,5'h00}, '{5'h04,5'h0F,5'h14,5'h0E,5'h05,5'h1E,5'h04},
    '{5'h18,5'h19,5'h02,5'h04,5'h08,5'h13,5'h03}, '{5'h08,5'h14,5'h14,5'h08,5'h15,5'h12,5'h0D},
    '{5'h04,5'h04,5'h00,5'h00,5'h00,5'h00,5'h00}, '{5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02},
    '{5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08}, '{5'h00,5'h04,5'h15,5'h0E,5'h15,5'h04,5'h00},
    '{5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00}, '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h04,5'h08},
    '{5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00}, '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h04},
    '{5'h01,5'h02,5'h02,5'h04,5'h08,5'h08,5'h10}, '{5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E},
    '{5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E}, '{5'h0E,5'h11,5'h01,5'h06,5'h08,5'h10,5'h1F},
    '{5'h0E,5'h11,5'h01,5'h06,5'h01,5'h11,5'h0E}, '{5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02},
    '{5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E}, '{5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E},
    '{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08}, '{5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E},
    '{5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C}, '{5'h00,5'h00,5'h04,5'h00,5'h00,5'h04,5'h00},
    '{5'h00,5'h00,5'h04,5'h00,5'h00,5'h04,5'h08}, '{5'h02,5'h04,5'h08,5'h10,5'h08,5'h04,5'h02},
    '{5'h00,5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00}, '{5'h08,5'h04,5'h02,5'h01,5'h02,5'h04,5'h08},
    '{5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04}, '{5'h0E,5'h11,5'h17,5'h15,5'h17,5'h10,5'h0E},
    '{5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11}, '{5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E},
    '{5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E}, '{5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E},
    '{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F}, '{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10},
    '{5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0E}, '{5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
    '{5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E}, '{5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C},
    '{5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11}, '{5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F},
    '{5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11}, '{5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11},
    '{5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E}, '{5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10},
    '{5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D}, '{5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11},
    '{5'h0E,5'h11,5'h10,5'h0E,5'h01,5'h11,5'h0E}, '{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
    '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E}, '{5'h11,5'h11,5'h11,5'h11,5'h0A,5'h0A,5'h04},
    '{5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11}, '{5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11},
    '{5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04}, '{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F},
    '{5'h0E,5'h08,5'h08,5'h08,5'h08,5'h08,5'h0E}, '{5'h10,5'h08,5'h08,5'h04,5'h02,5'h02,5'h01},
    '{5'h0E,5'h02,5'h02,5'h02,5'h02,5'h02,5'h0E}, '{5'h04,5'h0A,5'h11,5'h00,5'h00,5'h00,5'h00},
    '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F}, '{5'h08,5'h04,5'h00,5'h00,5'h00,5'h00,5'h00},
    '{5'h00,5'h00,5'h0E,5'h01,5'h0F,5'h11,5'h0F}, '{5'h10,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h1E},
    '{5'h00,5'h00,5'h0E,5'h11,5'h10,5'h11,5'h0E}, '{5'h01,5'h01,5'h0F,5'h11,5'h11,5'h11,5'h0F},
    '{5'h00,5'h00,5'h0E,5'h11,5'h1F,5'h10,5'h0E}, '{5'h06,5'h08,5'h1E,5'h08,5'h08,5'h08,5'h08},
    '{5'h00,5'h00,5'h0F,5'h11,5'h0F,5'h01,5'h0E}, '{5'h10,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h11},
    '{5'h04,5'h00,5'h0C,5'h04,5'h04,5'h04,5'h0E}, '{5'h02,5'h00,5'h06,5'h02,5'h02,5'h12,5'h0C},
    '{5'h10,5'h10,5'h12,5'h14,5'h18,5'h14,5'h12}, '{5'h0C,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E},
    '{5'h00,5'h00,5'h1A,5'h15,5'h15,5'h15,5'h15}, '{5'h00,5'h00,5'h1E,5'h11,5'h11,5'h11,5'h11},
    '{5'h00,5'h00,5'h0E,5'h11,5'h11,5'h11,5'h0E}, '{5'h00,5'h00,5'h1E,5'h11,5'h1E,5'h10,5'h10},
    '{5'h00,5'h00,5'h0F,5'h11,5'h0F,5'h01,5'h01}, '{5'h00,5'h00,5'h16,5'h19,5'h10,5'h10,5'h10},
    '{5'h00,5'h00,5'h0F,5'h10,5'h0E,5'h01,5'h1E}, '{5'h08,5'h08,5'h1E,5'h08,5'h08,5'h09,5'h06},
    '{5'h00,5'h00,5'h11,5'h11,5'h11,5'h11,5'h0F}, '{5'h00,5'h00,5'h11,5'h11,5'h11,5'h0A,5'h04},
    '{5'h00,5'h00,5'h11,5'h11,5'h15,5'h15,5'h0A}, '{5'h00,5'h00,5'h11,5'h0A,5'h04,5'h0A,5'h11},
    '{5'h00,5'h00,5'h11,5'h11,5'h0F,5'h01,5'h0E}, '{5'h00,5'h00,5'h1F,5'h02,5'h04,5'h08,5'h1F},
    '{5'h02,5'h04,5'h04,5'h08,5'h04,5'h04,5'h02}, '{5'h04,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
    '{5'h08,5'h04,5'h04,5'h02,5'h04,5'h04,5'h08}, '{5'h00,5'h00,5'h08,5'h15,5'h02,5'h00,5'h00}
  };

endpackage

>>> hw/rtl/ccgr_front.sv
// Front end: classifies a character code and fetches its glyph from the font table.
module ccgr_front (
  input  logic [ccgr_pkg::CODE_W-1:0] char_code,
  output ccgr_pkg::glyph_t            glyph
);

  logic                             has_glyph;
  logic [ccgr_pkg::CODE_W-1:0]      code_ofs;
  logic [ccgr_pkg::GLYPH_IDX_W-1:0] glyph_idx;

  // Codes outside the printable range get an empty glyph
  assign has_glyph = (char_code >= ccgr_pkg::GLYPH_FIRST) &&
                     (char_code <= ccgr_pkg::GLYPH_LAST);
  assign code_ofs  = char_code - ccgr_pkg::GLYPH_FIRST;
  assign glyph_idx = code_ofs[ccgr_pkg::GLYPH_IDX_W-1:0];

  assign glyph = has_glyph ? ccgr_pkg::GLYPH_ROM[glyph_idx] : '0;

endmodule

>>> hw/rtl/ccgr_queue.sv
// Small glyph queue between the front end and the row sequencer.
module ccgr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ccgr_pkg::glyph_t    push_data,
  input  logic                pop,
  output ccgr_pkg::glyph_t    pop_data,
  output ccgr_pkg::q_stat_t   stat
);

  localparam int Depth = ccgr_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  ccgr_pkg::glyph_t mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CntW'(Depth));
  assign pop_data   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth)) else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty) else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("push lost");

endmodule

>>> hw/rtl/ccgr_back.sv
// Back end: walks the cell rows of each queued glyph and drives the row output register.
module ccgr_back #(
  parameter int MAX_CELL_WIDTH  = ccgr_pkg::MAX_CELL_WIDTH_DEF,
  parameter int MAX_CELL_HEIGHT = ccgr_pkg::MAX_CELL_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [ccgr_pkg::CFG_W-1:0]     cell_width,
  input  logic [ccgr_pkg::CFG_W-1:0]     cell_height,
  input  ccgr_pkg::q_stat_t              q_stat,
  input  ccgr_pkg::glyph_t               q_data,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ccgr_pkg::ROW_IDX_W-1:0] row_index,
  output logic [ccgr_pkg::PIX_W-1:0]     row_pixels,
  output logic                           last_row
);

  localparam int CfgW = ccgr_pkg::CFG_W;
  localparam int RowW = $clog2(MAX_CELL_HEIGHT);
  localparam logic [CfgW-1:0] GlyphW = CfgW'(ccgr_pkg::GLYPH_W);
  localparam logic [CfgW-1:0] GlyphH = CfgW'(ccgr_pkg::GLYPH_H);
  localparam logic [CfgW-1:0] MaxW   = CfgW'(MAX_CELL_WIDTH);
  localparam logic [CfgW-1:0] MaxH   = CfgW'(MAX_CELL_HEIGHT);

  logic                   busy;
  logic [RowW-1:0]        row;
  ccgr_pkg::glyph_t       glyph;

  logic [CfgW-1:0]        w_eff;
  logic [CfgW-1:0]        h_eff;
  logic [CfgW-1:0]        off_x;
  logic [CfgW-1:0]        off_y;
  logic [CfgW-1:0]        row_ext;
  logic [CfgW-1:0]        glyph_row;
  logic                   in_glyph;
  logic [2:0]             gr;
  logic [ccgr_pkg::GLYPH_W-1:0] rom_bits;
  logic [ccgr_pkg::GLYPH_W-1:0] rev_bits;
  logic [ccgr_pkg::PIX_W-1:0]   pix;
  logic                   is_last;
  logic                   out_adv;
  logic                   load;

  // Clamped cell size and centering offsets
  always_comb begin
    if (cell_width < GlyphW) begin
      w_eff = GlyphW;
    end else if (cell_width > MaxW) begin
      w_eff = MaxW;
    end else begin
      w_eff = cell_width;
    end
    if (cell_height < GlyphH) begin
      h_eff = GlyphH;
    end else if (cell_height > MaxH) begin
      h_eff = MaxH;
    end else begin
      h_eff = cell_height;
    end
  end

  assign off_x = (w_eff - GlyphW) >> 1;
  assign off_y = (h_eff - GlyphH) >> 1;

  // Pixel row for the current row counter
  assign row_ext   = CfgW'(row);
  assign glyph_row = row_ext - off_y;
  assign in_glyph  = (row_ext >= off_y) && (glyph_row < GlyphH);
  assign gr        = glyph_row[2:0];
  assign rom_bits  = glyph[gr];
  // leftmost glyph column is bit 4, it lands on the lowest pixel bit
  assign rev_bits  = {rom_bits[0], rom_bits[1], rom_bits[2], rom_bits[3], rom_bits[4]};
  assign pix       = in_glyph ? (ccgr_pkg::PIX_W'(rev_bits) << off_x) : '0;
  assign is_last   = (row_ext == h_eff - 1'b1);

  // Sequencing: a new glyph is taken when idle or as the last row leaves
  assign out_adv = !out_valid || !out_stall;
  assign load    = !busy || (out_adv && is_last);
  assign q_pop   = load && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      glyph <= q_data;
    end
    if (out_adv) begin
      row_index  <= ccgr_pkg::ROW_IDX_W'(row);
      row_pixels <= pix;
      last_row   <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid <= busy;
      end
      if (q_pop) begin
        busy <= 1'b1;
        row  <= '0;
      end else if (busy && out_adv) begin
        if (is_last) begin
          busy <= 1'b0;
        end else begin
          row <= row + 1'b1;
        end
      end
    end
  end

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_row == (CfgW'(row_index) == h_eff - 1'b1)))
    else $error("last_row flag does not match cell height");

  a_row_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_row) |=>
      (out_valid && row_index == $past(row_index) + 1'b1))
    else $error("row sequence broken within a cell");

  a_new_cell: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_row) |=> (!out_valid || row_index == '0))
    else $error("new cell does not start at the top row");

endmodule

>>> hw/rtl/char_cell_glyph_rasterizer_unit.sv
// Top level of the text-mode character cell rasterizer with its register port.
//
//   port group  | direction | handshake          | payload
//   ------------+-----------+--------------------+-------------------------------------
//   input code  | in        | in_valid/in_stall  | char_code
//   row output  | out       | out_valid/out_stall| row_index, row_pixels, last_row
//   registers   | in/out    | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// One pixel row leaves per cycle while out_stall is low; a character is cell_height rows
// (clamped to 7..MAX_CELL_HEIGHT; 16 after reset), walked by the back end's row sequencer.
// Queued characters follow with no gap: the next glyph is loaded as the last row leaves.
// Accepted requests enter the glyph queue, then the glyph register, then the output register.
// rst is synchronous and clears the queue, sequencer and registers (width 8, height 16).
// out_stall holds a valid output row; in_stall rises only when the queue is full.
module char_cell_glyph_rasterizer_unit #(
  parameter int MAX_CELL_WIDTH  = ccgr_pkg::MAX_CELL_WIDTH_DEF,
  parameter int MAX_CELL_HEIGHT = ccgr_pkg::MAX_CELL_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // character requests
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ccgr_pkg::CODE_W-1:0]    char_code,
  // row results
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ccgr_pkg::ROW_IDX_W-1:0] row_index,
  output logic [ccgr_pkg::PIX_W-1:0]     row_pixels,
  output logic                           last_row
);

  logic [ccgr_pkg::CFG_W-1:0] cell_width;
  logic [ccgr_pkg::CFG_W-1:0] cell_height;
  ccgr_pkg::reg_idx_t         reg_sel;
  logic                       reg_wr;

  ccgr_pkg::glyph_t           front_glyph;
  ccgr_pkg::glyph_t           q_data;
  ccgr_pkg::q_stat_t          q_stat;
  logic                       q_push;
  logic                       q_pop;

  // Register port
  assign pready  = 1'b1;
  assign reg_sel = ccgr_pkg::reg_idx_t'(paddr[2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width  <= ccgr_pkg::CELL_WIDTH_RST;
      cell_height <= ccgr_pkg::CELL_HEIGHT_RST;
    end else if (reg_wr) begin
      case (reg_sel)
        ccgr_pkg::REG_CELL_WIDTH:  cell_width  <= pwdata[ccgr_pkg::CFG_W-1:0];
        ccgr_pkg::REG_CELL_HEIGHT: cell_height <= pwdata[ccgr_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ccgr_pkg::REG_CELL_WIDTH:  prdata = 32'(cell_width);
      ccgr_pkg::REG_CELL_HEIGHT: prdata = 32'(cell_height);
      default:                   prdata = '0;
    endcase
  end

  // Front end: glyph fetch into the queue
  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !in_stall;

  ccgr_front u_front (
    .char_code (char_code),
    .glyph     (front_glyph)
  );

  ccgr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_glyph),
    .pop       (q_pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  // Back end: row sequencer and output register
  ccgr_back #(
    .MAX_CELL_WIDTH  (MAX_CELL_WIDTH),
    .MAX_CELL_HEIGHT (MAX_CELL_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cell_width  (cell_width),
    .cell_height (cell_height),
    .q_stat      (q_stat),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .row_index   (row_index),
    .row_pixels  (row_pixels),
    .last_row    (last_row)
  );

endmodule
